@@ hdl/scr_pkg.sv @@
`timescale 1ns / 1ps

package scr_pkg;

  // field widths
  localparam int unsigned FREQ_W = 13;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned KIND_W = 2;

  // stream data widths, packed fields padded to whole bytes
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 24;

  // default table depth
  localparam int unsigned MAX_CHANNELS_DEF = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd2;

  // scan modes
  localparam logic MODE_RR  = 1'b0;
  localparam logic MODE_ALL = 1'b1;

endpackage

@@ hdl/scr_mem.sv @@
`timescale 1ns / 1ps

module scr_mem #(
  parameter int unsigned Depth = scr_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = scr_pkg::FREQ_W
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/scan_channel_round_robin.sv @@
`timescale 1ns / 1ps

// Round-robin scan channel scheduler. The block keeps a list of up to MAX_CHANNELS
// channel frequencies in a one-port-read, one-port-write synchronous memory, plus
// a rotating pointer. Every input transfer carries a kind in s_axis_tuser: clear
// (empties the list and rewinds the pointer, no output), append (stores one
// frequency, or when the list is full emits a single output transfer with the
// overflow flag in m_axis_tuser) and scan trigger. An allowed scan on a non-empty
// list walks the list from the pointer, wrapping at the end, skipping every entry
// equal to the home frequency (0 when there is no home), and emits one channel in
// round-robin mode or up to one full pass in all mode; m_axis_tlast marks the
// final channel of the run. Writing a different scan_mode through cfg_we_i /
// cfg_wdata_i rewinds the pointer; write it only while the block is idle.
// Flow: an append to a full list waits for the output register before its
// overflow transfer. A scan takes the input transfer, then visits one table entry
// per cycle through the single memory read port while output back-pressure does
// not stall it, then flushes the held last result. The last result waits in the
// output register while the next item is already taken. The table needs no
// clearing pass after reset.
module scan_channel_round_robin #(
  parameter int unsigned MAX_CHANNELS = scr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,     // scan_mode
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [12:0] channel_freq, [13] home_valid, [26:14] home_mhz, [27] scan_allowed
  input  logic [scr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic [scr_pkg::KIND_W-1:0]     s_axis_tuser,    // [1:0] kind
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [12:0] scan_freq, [18:13] run_index
  output logic [scr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,    // run_last
  output logic                           m_axis_tuser     // [0] overflow
);

  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);             // count / pointer
  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned FW = scr_pkg::FREQ_W;
  localparam int unsigned IW = scr_pkg::IDX_W;

  // controller states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // input field unpacking
  logic [FW-1:0]             in_freq;
  logic                      in_home_valid;
  logic [FW-1:0]             in_home_mhz;
  logic                      in_allowed;
  logic [scr_pkg::KIND_W-1:0] in_kind;

  assign in_freq       = s_axis_tdata[FW-1:0];
  assign in_home_valid = s_axis_tdata[FW];
  assign in_home_mhz   = s_axis_tdata[2*FW:FW+1];
  assign in_allowed    = s_axis_tdata[2*FW+1];
  assign in_kind       = s_axis_tuser;

  // control state
  logic [1:0]    state_q, state_d;
  logic          mode_q, mode_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;       // commit pointer, always wrapped
  logic [CW-1:0] rd_ptr_q, rd_ptr_d; // read-issue pointer, always wrapped
  logic [CW-1:0] iss_q, iss_d;       // reads issued this run
  logic [CW-1:0] steps_q, steps_d;   // entries examined this run
  logic [CW-1:0] used_q, used_d;     // channels found this run
  logic          rv_q, rv_d;         // read data valid at memory output
  logic          pend_q, pend_d;     // held result, last flag not known yet

  // payload state
  logic [FW-1:0] home_q, home_d;
  logic [FW-1:0] pend_freq_q, pend_freq_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [FW-1:0] out_freq_q, out_freq_d;
  logic [IW-1:0] out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  // memory ports
  logic          mem_we;
  logic          mem_re;
  logic [FW-1:0] mem_rdata;

  logic          acc;
  logic          out_free;
  logic          hit;
  logic          stall;
  logic          consume;
  logic          issue;
  logic          done;
  logic [CW-1:0] limit;
  logic [CW-1:0] used_inc;
  logic [CW-1:0] steps_inc;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_start;
  logic [CW-1:0] rd_ptr_inc;
  logic          full;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (count_q == CW'(MAX_CHANNELS));

  assign mem_we = acc && (in_kind == scr_pkg::KIND_APPEND) && !full;

  // walk datapath: one table entry examined per cycle unless output back-pressure stalls it
  assign hit        = (mem_rdata != home_q);
  assign stall      = rv_q && hit && pend_q && !out_free;
  assign consume    = (state_q == ST_WALK) && rv_q && !stall;
  assign issue      = (state_q == ST_WALK) && (iss_q != count_q) && (!rv_q || consume);
  assign limit      = (mode_q == scr_pkg::MODE_ALL) ? count_q : CW'(1);
  assign used_inc   = used_q + CW'(1);
  assign steps_inc  = steps_q + CW'(1);
  assign done       = consume && ((hit && (used_inc == limit)) || (steps_inc == count_q));
  assign ptr_inc    = ((ptr_q + CW'(1)) == count_q) ? '0 : (ptr_q + CW'(1));
  assign ptr_start  = (ptr_q >= count_q) ? '0 : ptr_q;
  assign rd_ptr_inc = ((rd_ptr_q + CW'(1)) == count_q) ? '0 : (rd_ptr_q + CW'(1));
  assign mem_re     = issue;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    rd_ptr_d    = rd_ptr_q;
    iss_d       = iss_q;
    steps_d     = steps_q;
    used_d      = used_q;
    rv_d        = rv_q;
    pend_d      = pend_q;
    home_d      = home_q;
    pend_freq_d = pend_freq_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_freq_d  = out_freq_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_kind)
            scr_pkg::KIND_CLEAR: begin
              count_d = '0;
              ptr_d   = '0;
            end
            scr_pkg::KIND_APPEND: begin
              if (full) begin
                state_d = ST_OVF;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            scr_pkg::KIND_SCAN: begin
              if (in_allowed && (count_q != '0)) begin
                state_d  = ST_WALK;
                ptr_d    = ptr_start;
                rd_ptr_d = ptr_start;
                iss_d    = '0;
                steps_d  = '0;
                used_d   = '0;
                rv_d     = 1'b0;
                pend_d   = 1'b0;
                home_d   = in_home_valid ? in_home_mhz : '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_inc;
          iss_d    = iss_q + CW'(1);
        end
        if (consume) begin
          // pointer wraps right away so a later append never lands under it
          ptr_d   = ptr_inc;
          steps_d = steps_inc;
          if (hit) begin
            // release the previously held result, it is not the last one
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_freq_d  = pend_freq_q;
              out_idx_d   = pend_idx_q;
              out_last_d  = 1'b0;
              out_ovf_d   = 1'b0;
            end
            pend_d      = 1'b1;
            pend_freq_d = mem_rdata;
            pend_idx_d  = IW'(used_q);
            used_d      = used_inc;
          end
        end
        if (done) begin
          state_d = ST_FLUSH;
          rv_d    = 1'b0;
        end else begin
          rv_d = issue || stall;
        end
      end
      ST_FLUSH: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_freq_d  = pend_freq_q;
          out_idx_d   = pend_idx_q;
          out_last_d  = 1'b1;
          out_ovf_d   = 1'b0;
          pend_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_freq_d  = '0;
          out_idx_d   = '0;
          out_last_d  = 1'b0;
          out_ovf_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // mode change rewinds the pointer; the user writes it only while idle, the block does not enforce this
    if (cfg_we_i && (cfg_wdata_i != mode_q)) begin
      mode_d = cfg_wdata_i;
      ptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= scr_pkg::MODE_RR;
      count_q     <= '0;
      ptr_q       <= '0;
      rd_ptr_q    <= '0;
      iss_q       <= '0;
      steps_q     <= '0;
      used_q      <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      iss_q       <= iss_d;
      steps_q     <= steps_d;
      used_q      <= used_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    home_q      <= home_d;
    pend_freq_q <= pend_freq_d;
    pend_idx_q  <= pend_idx_d;
    out_freq_q  <= out_freq_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  scr_mem #(
    .Depth (MAX_CHANNELS),
    .AddrW (AW),
    .DataW (FW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_freq),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(scr_pkg::M_TDATA_W - FW - IW){1'b0}}, out_idx_q, out_freq_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

`ifndef SYNTH
  // never more channels found than entries examined
  a_used_le_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (used_q <= steps_q))
    else $error("found more channels than entries examined");

  // list never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_CHANNELS))
    else $error("channel count past capacity");

  // a held result exists only during a scan run
  a_pend_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((state_q == ST_WALK) || (state_q == ST_FLUSH)))
    else $error("held result outside a scan run");

  // an overflow transfer carries no channel and no run end
  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ovf_q) |-> (!out_last_q && (out_freq_q == '0) && (out_idx_q == '0)))
    else $error("overflow transfer with channel payload");

  // scan run ends with the last flag on the released result
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && pend_q && out_free) |=> (out_valid_q && out_last_q))
    else $error("run end not flagged");
`endif

endmodule
